[rtl/core/tms_pkg.sv]
// ----------------------------------------------------------------------------
// tms_pkg
// Shared constants and helpers for the temporal macro scanner.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int unsigned WIN_LEN  = 14;            // history cells
	localparam int unsigned BUF_LEN  = WIN_LEN + 1;   // history plus incoming byte
	localparam int unsigned NAME_MAX = 13;

	typedef logic [7:0] byte_t;

	// names right-aligned in a 13-byte field, first char in the highest used byte
	localparam logic [NAME_MAX*8-1:0] NAME_DATE  = (NAME_MAX*8)'("__DATE__");
	localparam logic [NAME_MAX*8-1:0] NAME_TIME  = (NAME_MAX*8)'("__TIME__");
	localparam logic [NAME_MAX*8-1:0] NAME_STAMP = (NAME_MAX*8)'("__TIMESTAMP__");
	localparam int unsigned LEN_DATE  = 8;
	localparam int unsigned LEN_TIME  = 8;
	localparam int unsigned LEN_STAMP = 13;

	localparam byte_t CH_UNDERSCORE = 8'h5F;

	// '_' or ASCII alphanumeric
	function automatic logic is_ident(input byte_t b);
		return (b == CH_UNDERSCORE) ||
			(b >= 8'h30 && b <= 8'h39) ||
			(b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

endpackage

[rtl/core/tms_in_if.sv]
// ----------------------------------------------------------------------------
// tms_in_if
// Text byte channel: one byte per transaction, with a last-byte flag.
// ----------------------------------------------------------------------------
interface tms_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/core/tms_out_if.sv]
// ----------------------------------------------------------------------------
// tms_out_if
// Result channel: three found flags per text.
// ----------------------------------------------------------------------------
interface tms_out_if;
	logic valid;
	logic ready;
	logic date_found;
	logic time_found;
	logic stamp_found;

	modport source (output valid, output date_found, output time_found,
		output stamp_found, input ready);
	modport sink   (input valid, input date_found, input time_found,
		input stamp_found, output ready);
endinterface

[rtl/core/tms_cell.sv]
// ----------------------------------------------------------------------------
// tms_cell
// One history cell: holds a byte and its valid mark, takes its neighbor's
// byte on every accepted mid-text transaction and flags identifier characters.
// ----------------------------------------------------------------------------
module tms_cell
	import tms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  logic  flush,
	input  byte_t d_byte,
	input  logic  d_valid,
	output byte_t q_byte,
	output logic  q_valid,
	output logic  q_ident
);

	byte_t byte_q;
	logic  valid_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flush) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d_valid;
		end
	end

	assign q_byte  = byte_q;
	assign q_valid = valid_q;
	assign q_ident = is_ident(byte_q);

endmodule

[rtl/core/temporal_macro_scanner.sv]
// ----------------------------------------------------------------------------
// temporal_macro_scanner
// Whole-identifier search for __DATE__, __TIME__ and __TIMESTAMP__.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle with no gaps between texts. Bytes shift
// through a chain of 14 history cells; every cycle the cells plus the
// incoming byte are compared against the three names at the two possible end
// positions, and hits set sticky flags. The transaction that carries
// end_of_text produces one result, registered, on the next cycle, and the
// chain starts the following text from empty. Input is only held off while a
// result waits in the output register and the sink is not ready.
module temporal_macro_scanner
	import tms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tms_in_if.sink    in_ch,
	tms_out_if.source out_ch
);

	logic accept;
	logic shift;
	logic flush;

	byte_t              hist_byte  [WIN_LEN];
	logic [WIN_LEN-1:0] hist_valid;
	logic [WIN_LEN-1:0] hist_ident;
	byte_t              cur_byte;

	logic date_seen_q, time_seen_q, stamp_seen_q;
	logic out_valid_q;
	logic out_date_q, out_time_q, out_stamp_q;

	logic hit_date, hit_time, hit_stamp;

	assign cur_byte    = in_ch.text_byte;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign shift       = accept && !in_ch.end_of_text;
	assign flush       = accept && in_ch.end_of_text;

	for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
		byte_t d_byte;
		logic  d_valid;
		if (i == WIN_LEN - 1) begin : g_head
			assign d_byte  = cur_byte;
			assign d_valid = 1'b1;
		end else begin : g_body
			assign d_byte  = hist_byte[i+1];
			assign d_valid = hist_valid[i+1];
		end
		tms_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.flush   (flush),
			.d_byte  (d_byte),
			.d_valid (d_valid),
			.q_byte  (hist_byte[i]),
			.q_valid (hist_valid[i]),
			.q_ident (hist_ident[i])
		);
	end

	// name of length len ending at buffer index last; buffer index WIN_LEN is
	// the incoming byte, always valid. Called with constant arguments only.
	function automatic logic name_hit(
		input byte_t                  hb [WIN_LEN],
		input logic [WIN_LEN-1:0]     hv,
		input logic [WIN_LEN-1:0]     hi,
		input byte_t                  cb,
		input int unsigned            last,
		input logic [NAME_MAX*8-1:0]  name,
		input int unsigned            len
	);
		logic        ok;
		int unsigned start;
		int unsigned pos;
		byte_t       b;
		ok    = 1'b1;
		start = last + 1 - len;
		for (int unsigned k = 0; k < NAME_MAX; k++) begin
			if (k < len) begin
				pos = start + k;
				b   = (pos == WIN_LEN) ? cb : hb[pos];
				if (b != name[8*(len-k)-1 -: 8]) ok = 1'b0;
				if (pos < WIN_LEN && !hv[pos]) ok = 1'b0;
			end
		end
		// byte in front must be absent or a non-identifier
		if (hv[start-1] && hi[start-1]) ok = 1'b0;
		return ok;
	endfunction

	always_comb begin
		logic closed;
		closed    = !is_ident(cur_byte);
		hit_date  = (closed && name_hit(hist_byte, hist_valid, hist_ident, cur_byte,
			WIN_LEN-1, NAME_DATE, LEN_DATE)) ||
			(in_ch.end_of_text && name_hit(hist_byte, hist_valid, hist_ident, cur_byte,
			WIN_LEN, NAME_DATE, LEN_DATE));
		hit_time  = (closed && name_hit(hist_byte, hist_valid, hist_ident, cur_byte,
			WIN_LEN-1, NAME_TIME, LEN_TIME)) ||
			(in_ch.end_of_text && name_hit(hist_byte, hist_valid, hist_ident, cur_byte,
			WIN_LEN, NAME_TIME, LEN_TIME));
		hit_stamp = (closed && name_hit(hist_byte, hist_valid, hist_ident, cur_byte,
			WIN_LEN-1, NAME_STAMP, LEN_STAMP)) ||
			(in_ch.end_of_text && name_hit(hist_byte, hist_valid, hist_ident, cur_byte,
			WIN_LEN, NAME_STAMP, LEN_STAMP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_seen_q  <= 1'b0;
			time_seen_q  <= 1'b0;
			stamp_seen_q <= 1'b0;
		end else if (flush) begin
			date_seen_q  <= 1'b0;
			time_seen_q  <= 1'b0;
			stamp_seen_q <= 1'b0;
		end else if (shift) begin
			date_seen_q  <= date_seen_q  | hit_date;
			time_seen_q  <= time_seen_q  | hit_time;
			stamp_seen_q <= stamp_seen_q | hit_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush) begin
			out_date_q  <= date_seen_q  | hit_date;
			out_time_q  <= time_seen_q  | hit_time;
			out_stamp_q <= stamp_seen_q | hit_stamp;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.date_found  = out_date_q;
	assign out_ch.time_found  = out_time_q;
	assign out_ch.stamp_found = out_stamp_q;

endmodule

[rtl/core/tms_checker.sv]
// ----------------------------------------------------------------------------
// tms_checker
// Port-level checks for the temporal macro scanner.
// ----------------------------------------------------------------------------
module tms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_end,
	input logic out_valid,
	input logic out_ready
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// last byte of a text always yields a result next cycle
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_end |=> out_valid)
		else $error("missing result after last byte");

	// a mid-text transaction never creates a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_end |=> !$rose(out_valid))
		else $error("result without last byte");

	// input is blocked only by a waiting result
	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without pending result");

endmodule

bind temporal_macro_scanner tms_checker u_tms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_end    (in_ch.end_of_text),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready)
);
